@@ rtl/css_pkg.sv @@
`default_nettype none
package css_pkg;

	localparam int DEPTH  = 64;
	localparam int ELEM_W = 16;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic [ADDR_W-1:0]        addr_t;
	typedef logic [CNT_W-1:0]         cnt_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PRIME,
		ST_FIRST,
		ST_SCAN,
		ST_TAIL,
		ST_EMIT_RD,
		ST_EMIT_PUT
	} state_t;

	typedef enum logic {
		DIR_UP,
		DIR_DOWN
	} dir_t;

	// result of one compare-exchange step of a pass
	typedef struct packed {
		elem_t wr_data;
		elem_t carry;
		logic  swap;
	} cx_res_t;

endpackage
`default_nettype wire

@@ rtl/cocktail_shaker_sorter_unit.sv @@
// Load: one element per cycle into a 64-entry store; a beat with last set starts the sort.
// Sort: each pass runs PRIME, FIRST, one SCAN step per compare, then TAIL (at most one
// store read and one write per cycle); worst case for 64 elements is 63 passes and 2016
// compares. Emit: store read, then output register, one result at a time. Next set loads
// while the final result waits in the output register.
// Reset (arst_n low) clears control and output valid; store contents stay undefined.
`default_nettype none
module cocktail_shaker_sorter_unit (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_stall,
	input  css_pkg::elem_t        value,
	input  wire                   last,
	output logic                  out_valid,
	input  wire                   out_stall,
	output css_pkg::elem_t        value_res,
	output logic                  last_res,
	output logic                  overflow
);

	css_pkg::state_t  state_q, state_d;
	css_pkg::dir_t    dir_q;
	css_pkg::addr_t   lo_q, hi_q, lswap_q, cur_q, k_q;
	css_pkg::cnt_t    count_q, cnt_fin;
	logic             ovf_q;
	css_pkg::elem_t   carry_q;

	css_pkg::elem_t   mem_q [css_pkg::DEPTH];
	css_pkg::elem_t   rdata_q;
	logic             we, re;
	css_pkg::addr_t   waddr, raddr;
	css_pkg::elem_t   wdata;

	logic             ovalid_q;
	css_pkg::elem_t   value_res_q;
	logic             last_res_q, overflow_q;

	logic             in_accept, out_free, full, k_last;
	css_pkg::addr_t   start_a, end_a, nbr, nbr2;
	css_pkg::cx_res_t cx;

	css_cx u_cx (
		.dir  (dir_q),
		.carry(carry_q),
		.data (rdata_q),
		.res  (cx)
	);

	assign in_stall  = (state_q != css_pkg::ST_LOAD);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !ovalid_q || !out_stall;
	assign full      = (count_q == css_pkg::cnt_t'(css_pkg::DEPTH));
	assign cnt_fin   = full ? count_q : count_q + css_pkg::cnt_t'(1);
	assign k_last    = ((css_pkg::cnt_t'(k_q) + css_pkg::cnt_t'(1)) == count_q);

	assign start_a = (dir_q == css_pkg::DIR_UP) ? lo_q : hi_q;
	assign end_a   = (dir_q == css_pkg::DIR_UP) ? hi_q : lo_q;
	assign nbr     = (dir_q == css_pkg::DIR_UP) ? cur_q + css_pkg::addr_t'(1)
	                                            : cur_q - css_pkg::addr_t'(1);
	assign nbr2    = (dir_q == css_pkg::DIR_UP) ? nbr + css_pkg::addr_t'(1)
	                                            : nbr - css_pkg::addr_t'(1);

	assign out_valid = ovalid_q;
	assign value_res = value_res_q;
	assign last_res  = last_res_q;
	assign overflow  = overflow_q;

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = cur_q;
		wdata   = cx.wr_data;
		re      = 1'b0;
		raddr   = cur_q;
		unique case (state_q)
			css_pkg::ST_LOAD: begin
				if (in_accept) begin
					if (!full) begin
						we    = 1'b1;
						waddr = count_q[css_pkg::ADDR_W-1:0];
						wdata = value;
					end
					if (last) begin
						state_d = (cnt_fin > css_pkg::cnt_t'(1)) ? css_pkg::ST_PRIME
						                                       : css_pkg::ST_EMIT_RD;
					end
				end
			end
			css_pkg::ST_PRIME: begin
				re      = 1'b1;
				raddr   = start_a;
				state_d = css_pkg::ST_FIRST;
			end
			css_pkg::ST_FIRST: begin
				re      = 1'b1;
				raddr   = nbr;
				state_d = css_pkg::ST_SCAN;
			end
			css_pkg::ST_SCAN: begin
				// write behind, read ahead: the two addresses never coincide
				we = 1'b1;
				if (nbr == end_a) begin
					state_d = css_pkg::ST_TAIL;
				end else begin
					re    = 1'b1;
					raddr = nbr2;
				end
			end
			css_pkg::ST_TAIL: begin
				we    = 1'b1;
				waddr = end_a;
				wdata = carry_q;
				if (dir_q == css_pkg::DIR_UP) begin
					state_d = (lswap_q > lo_q) ? css_pkg::ST_PRIME : css_pkg::ST_EMIT_RD;
				end else begin
					state_d = (lswap_q < hi_q) ? css_pkg::ST_PRIME : css_pkg::ST_EMIT_RD;
				end
			end
			css_pkg::ST_EMIT_RD: begin
				re      = 1'b1;
				raddr   = k_q;
				state_d = css_pkg::ST_EMIT_PUT;
			end
			css_pkg::ST_EMIT_PUT: begin
				if (out_free) begin
					state_d = k_last ? css_pkg::ST_LOAD : css_pkg::ST_EMIT_RD;
				end
			end
			default: begin
				state_d = css_pkg::ST_LOAD;
			end
		endcase
	end

	// element store
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= css_pkg::ST_LOAD;
			dir_q    <= css_pkg::DIR_UP;
			lo_q     <= '0;
			hi_q     <= '0;
			lswap_q  <= '0;
			k_q      <= '0;
			count_q  <= '0;
			ovf_q    <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_free) begin
				ovalid_q <= (state_q == css_pkg::ST_EMIT_PUT);
			end
			case (state_q)
				css_pkg::ST_LOAD: begin
					if (in_accept) begin
						count_q <= cnt_fin;
						if (full) begin
							ovf_q <= 1'b1;
						end
						if (last) begin
							lo_q    <= '0;
							hi_q    <= css_pkg::addr_t'(cnt_fin - css_pkg::cnt_t'(1));
							lswap_q <= css_pkg::addr_t'(cnt_fin - css_pkg::cnt_t'(1));
							dir_q   <= css_pkg::DIR_UP;
							k_q     <= '0;
						end
					end
				end
				css_pkg::ST_SCAN: begin
					if (cx.swap) begin
						lswap_q <= cur_q;
					end
				end
				css_pkg::ST_TAIL: begin
					if (dir_q == css_pkg::DIR_UP) begin
						hi_q  <= lswap_q;
						// empty upward pass still moves the lower bound
						if (!(lswap_q > lo_q)) begin
							lo_q <= lswap_q;
						end
						dir_q <= css_pkg::DIR_DOWN;
					end else begin
						lo_q  <= lswap_q;
						dir_q <= css_pkg::DIR_UP;
					end
				end
				css_pkg::ST_EMIT_PUT: begin
					if (out_free) begin
						k_q <= k_q + css_pkg::addr_t'(1);
						if (k_last) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							lo_q    <= '0;
							hi_q    <= '0;
							lswap_q <= '0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == css_pkg::ST_PRIME) begin
			cur_q <= start_a;
		end else if (state_q == css_pkg::ST_SCAN) begin
			cur_q <= nbr;
		end
		if (state_q == css_pkg::ST_FIRST) begin
			carry_q <= rdata_q;
		end else if (state_q == css_pkg::ST_SCAN) begin
			carry_q <= cx.carry;
		end
		if ((state_q == css_pkg::ST_EMIT_PUT) && out_free) begin
			value_res_q <= rdata_q;
			last_res_q  <= k_last;
			overflow_q  <= ovf_q;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= css_pkg::cnt_t'(css_pkg::DEPTH))
		else $error("element count beyond store depth");

	a_pass_span: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == css_pkg::ST_PRIME) |-> (lo_q < hi_q))
		else $error("pass started on an empty span");

	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == css_pkg::ST_SCAN) |-> (cur_q != end_a))
		else $error("pass ran past its bound");

	a_emit_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == css_pkg::ST_EMIT_PUT) |-> (css_pkg::cnt_t'(k_q) < count_q))
		else $error("emit index beyond stored elements");

endmodule
`default_nettype wire

@@ rtl/css_cx.sv @@
`default_nettype none
// Compare-exchange of the element carried along a pass against its next neighbor.
// Upward passes carry the larger one, downward passes the smaller one; ties never swap.
module css_cx (
	input  css_pkg::dir_t    dir,
	input  css_pkg::elem_t   carry,
	input  css_pkg::elem_t   data,
	output css_pkg::cx_res_t res
);

	logic swap;

	always_comb begin
		if (dir == css_pkg::DIR_UP) begin
			swap = (carry > data);
		end else begin
			swap = (carry < data);
		end
		res.swap    = swap;
		res.wr_data = swap ? data : carry;
		res.carry   = swap ? carry : data;
	end

endmodule
`default_nettype wire
